FILE: src/threshold_glitch_remover_assert.svh
// ---------------------------------------------------------------------------
// Threshold glitch remover assertion macros
// Concurrent assertion shorthands used by the datapath RTL of the block.
// ---------------------------------------------------------------------------
`ifndef THRESHOLD_GLITCH_REMOVER_ASSERT_SVH
`define THRESHOLD_GLITCH_REMOVER_ASSERT_SVH

// A condition that must hold at every clock edge outside reset.
`define TGR_ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

// A condition that must hold in the same cycle as its trigger.
`define TGR_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

FILE: src/tgr_pkg.sv
// ---------------------------------------------------------------------------
// Threshold glitch remover package
// Register indexes, repair mode codes, controller states and the command and
// status bundles between the controller and the datapath.
// ---------------------------------------------------------------------------
`default_nettype none

package tgr_pkg;

    localparam int unsigned CFG_WIDTH = 24;

    localparam logic REG_THRESHOLD   = 1'b0;
    localparam logic REG_REPAIR_MODE = 1'b1;

    localparam logic [1:0] MODE_INTERP = 2'd1;
    localparam logic [1:0] MODE_ZERO   = 2'd2;

    localparam logic [CFG_WIDTH-1:0] THRESHOLD_RESET = 24'h800000;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_DIV,
        S_READ,
        S_EMIT,
        S_FINAL
    } t_state;

    typedef struct packed {
        logic load_in;
        logic absorb;
        logic start_div;
        logic init_run;
        logic rd_step;
        logic emit_held;
        logic emit_final;
    } t_cmd;

    typedef struct packed {
        logic glitch;
        logic rend;
        logic in_glitch;
        logic gap_full;
        logic mode_interp;
        logic div_done;
        logic out_free;
        logic idx_last;
    } t_sts;

endpackage

`default_nettype wire

FILE: src/tgr_div.sv
// ---------------------------------------------------------------------------
// Threshold glitch remover divider
// Restoring unsigned divider that produces one quotient bit per cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module tgr_div #(
    parameter int unsigned DW = 24,
    parameter int unsigned VW = 7
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [DW-1:0] i_dividend,
    input  logic [VW-1:0] i_divisor,
    output logic          o_done,
    output logic [DW-1:0] o_quot,
    output logic [VW-1:0] o_rem
);

    localparam int unsigned CNTW = $clog2(DW + 1);

    logic            r_busy;
    logic            r_done;
    logic [CNTW-1:0] r_cnt;
    logic [DW-1:0]   r_quot;
    logic [VW-1:0]   r_rem;
    logic [VW-1:0]   r_div;

    logic [VW:0]     w_trial;
    logic [VW:0]     w_diff;
    logic            w_ge;

    assign w_trial = {r_rem, r_quot[DW-1]};
    assign w_ge    = w_trial >= {1'b0, r_div};
    assign w_diff  = w_trial - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == CNTW'(1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNTW'(DW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNTW'(1);
                if (r_cnt == CNTW'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quot <= i_dividend;
            r_rem  <= '0;
            r_div  <= i_divisor;
        end else if (r_busy) begin
            r_quot <= {r_quot[DW-2:0], w_ge};
            r_rem  <= w_ge ? w_diff[VW-1:0] : w_trial[VW-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
    assign o_rem  = r_rem;

endmodule

`default_nettype wire

FILE: src/tgr_dp.sv
// ---------------------------------------------------------------------------
// Threshold glitch remover datapath
// Holds the configuration, the run state, the held sample memory, the line
// interpolation registers and the output register.
// ---------------------------------------------------------------------------
`default_nettype none
`include "threshold_glitch_remover_assert.svh"

module tgr_dp #(
    parameter int unsigned SAMPLE_WIDTH = 24,
    parameter int unsigned MAX_GAP      = 63
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  tgr_pkg::t_cmd                  i_cmd,
    output tgr_pkg::t_sts                  o_sts,
    input  logic [SAMPLE_WIDTH-1:0]        i_sample,
    input  logic                           i_record_end,
    input  logic                           i_cfg_we,
    input  logic                           i_cfg_addr,
    input  logic [tgr_pkg::CFG_WIDTH-1:0]  i_cfg_wdata,
    input  logic                           i_m_ready,
    output logic                           o_m_valid,
    output logic [SAMPLE_WIDTH-1:0]        o_sample_out,
    output logic                           o_repaired,
    output logic                           o_run_last,
    output logic                           o_record_end_out
);

    import tgr_pkg::*;

    localparam int unsigned SW   = SAMPLE_WIDTH;
    localparam int unsigned AW   = (MAX_GAP > 1) ? $clog2(MAX_GAP) : 1;
    localparam int unsigned GCW  = $clog2(MAX_GAP + 1);
    localparam int unsigned MW   = $clog2(MAX_GAP + 2);
    localparam int unsigned QW   = SW + 2;
    localparam int unsigned CMPW = (SW > CFG_WIDTH) ? SW : CFG_WIDTH;

    logic [CFG_WIDTH-1:0] r_thr;
    logic [1:0]           r_mode;

    logic [SW-1:0]  r_s;
    logic           r_rend;
    logic           r_in_glitch;
    logic [SW-1:0]  r_left;
    logic [GCW-1:0] r_gap;
    logic [GCW-1:0] r_idx;

    logic [SW-1:0]  r_mem [MAX_GAP];
    logic [SW-1:0]  r_rd;

    logic [QW-1:0]  r_q;
    logic [MW-1:0]  r_r;
    logic [SW:0]    r_dq;
    logic [MW-1:0]  r_dr;

    logic           r_o_valid;
    logic [SW-1:0]  r_o_sample;
    logic           r_o_rep;
    logic           r_o_last;
    logic           r_o_rend;

    logic [SW-1:0]  w_abs;
    logic           w_glitch;
    logic [MW-1:0]  w_m;
    logic [SW:0]    w_d;
    logic [SW:0]    w_dneg;
    logic [SW-1:0]  w_dabs;
    logic           w_div_done;
    logic [SW-1:0]  w_quot;
    logic [MW-1:0]  w_rem;
    logic [SW:0]    w_qext;
    logic [SW:0]    w_dq;
    logic [MW-1:0]  w_dr;
    logic [MW:0]    w_rs;
    logic [MW:0]    w_rsub;
    logic           w_wrap;
    logic [QW-1:0]  w_q_step;
    logic [QW-1:0]  w_q_trunc;
    logic [SW-1:0]  w_held_val;
    logic           w_held_rep;
    logic           w_out_free;

    // Glitch test on the captured sample.
    assign w_abs    = r_s[SW-1] ? (~r_s + SW'(1)) : r_s;
    assign w_glitch = CMPW'(w_abs) >= CMPW'(r_thr);

    // The line spans the held samples plus one, so the divisor is the gap plus one.
    assign w_m    = MW'(r_gap) + MW'(1);
    assign w_d    = {r_s[SW-1], r_s} - {r_left[SW-1], r_left};
    assign w_dneg = -w_d;
    assign w_dabs = w_d[SW] ? w_dneg[SW-1:0] : w_d[SW-1:0];

    tgr_div #(
        .DW (SW),
        .VW (MW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.start_div),
        .i_dividend (w_dabs),
        .i_divisor  (w_m),
        .o_done     (w_div_done),
        .o_quot     (w_quot),
        .o_rem      (w_rem)
    );

    // Floor division of the signed step from the magnitude result.
    always_comb begin
        w_qext = {1'b0, w_quot};
        if (w_d[SW] && (w_rem != '0)) begin
            w_dq = ~w_qext;
            w_dr = w_m - w_rem;
        end else if (w_d[SW]) begin
            w_dq = -w_qext;
            w_dr = w_rem;
        end else begin
            w_dq = w_qext;
            w_dr = w_rem;
        end
    end

    // One step along the line: quotient and remainder advance by the step.
    assign w_rs     = {1'b0, r_r} + {1'b0, r_dr};
    assign w_wrap   = w_rs >= {1'b0, w_m};
    assign w_rsub   = w_rs - {1'b0, w_m};
    assign w_q_step = r_q + {{(QW-SW-1){r_dq[SW]}}, r_dq} + QW'(w_wrap);

    // A negative floor quotient with a remainder rounds up towards zero.
    assign w_q_trunc = (r_q[QW-1] && (r_r != '0)) ? (r_q + QW'(1)) : r_q;

    always_comb begin
        unique case (r_mode)
            MODE_INTERP: begin
                w_held_val = w_q_trunc[SW-1:0];
                w_held_rep = 1'b1;
            end
            MODE_ZERO: begin
                w_held_val = '0;
                w_held_rep = 1'b1;
            end
            default: begin
                w_held_val = r_rd;
                w_held_rep = 1'b0;
            end
        endcase
    end

    assign w_out_free = !r_o_valid || i_m_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr       <= THRESHOLD_RESET;
            r_mode      <= '0;
            r_in_glitch <= 1'b0;
            r_left      <= '0;
            r_gap       <= '0;
            r_o_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    REG_THRESHOLD:   r_thr  <= i_cfg_wdata;
                    REG_REPAIR_MODE: r_mode <= i_cfg_wdata[1:0];
                    default:         r_mode <= r_mode;
                endcase
            end
            if (i_cmd.absorb) begin
                r_in_glitch <= 1'b1;
                r_gap       <= r_gap + GCW'(1);
            end
            if (i_cmd.emit_final) begin
                r_in_glitch <= 1'b0;
                r_gap       <= '0;
                r_left      <= r_rend ? '0 : r_s;
            end
            if (i_cmd.emit_held || i_cmd.emit_final) begin
                r_o_valid <= 1'b1;
            end else if (i_m_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_s    <= i_sample;
            r_rend <= i_record_end;
        end
        if (i_cmd.init_run) begin
            r_idx <= '0;
            r_q   <= {{(QW-SW){r_left[SW-1]}}, r_left};
            r_r   <= '0;
            r_dq  <= w_dq;
            r_dr  <= w_dr;
        end else if (i_cmd.rd_step) begin
            r_q <= w_q_step;
            r_r <= w_wrap ? w_rsub[MW-1:0] : w_rs[MW-1:0];
        end else if (i_cmd.emit_held) begin
            r_idx <= r_idx + GCW'(1);
        end
        if (i_cmd.emit_held) begin
            r_o_sample <= w_held_val;
            r_o_rep    <= w_held_rep;
            r_o_last   <= 1'b0;
            r_o_rend   <= 1'b0;
        end else if (i_cmd.emit_final) begin
            r_o_sample <= r_s;
            r_o_rep    <= 1'b0;
            r_o_last   <= 1'b1;
            r_o_rend   <= r_rend;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.absorb) begin
            r_mem[r_gap[AW-1:0]] <= r_s;
        end
        if (i_cmd.rd_step) begin
            r_rd <= r_mem[r_idx[AW-1:0]];
        end
    end

    assign o_sts.glitch      = w_glitch;
    assign o_sts.rend        = r_rend;
    assign o_sts.in_glitch   = r_in_glitch;
    assign o_sts.gap_full    = r_gap == GCW'(MAX_GAP);
    assign o_sts.mode_interp = r_mode == MODE_INTERP;
    assign o_sts.div_done    = w_div_done;
    assign o_sts.out_free    = w_out_free;
    assign o_sts.idx_last    = r_idx == (r_gap - GCW'(1));

    assign o_m_valid        = r_o_valid;
    assign o_sample_out     = r_o_sample;
    assign o_repaired       = r_o_rep;
    assign o_run_last       = r_o_last;
    assign o_record_end_out = r_o_rend;

    `TGR_ASSERT_ALWAYS(a_gap_bound, i_clk, i_rst_n, r_gap <= GCW'(MAX_GAP), "held count overflow")
    `TGR_ASSERT_ALWAYS(a_run_state, i_clk, i_rst_n, r_in_glitch == (r_gap != '0), "run flag and held count disagree")
    `TGR_ASSERT_IMPLY(a_absorb_room, i_clk, i_rst_n, i_cmd.absorb, r_gap != GCW'(MAX_GAP), "sample held into a full memory")
    `TGR_ASSERT_IMPLY(a_out_free, i_clk, i_rst_n, i_cmd.emit_held || i_cmd.emit_final, !r_o_valid || i_m_ready, "output register overwritten")

endmodule

`default_nettype wire

FILE: src/tgr_ctrl.sv
// ---------------------------------------------------------------------------
// Threshold glitch remover controller
// Sequences acceptance, run holding, the divider and the emission of held
// and closing samples.
// ---------------------------------------------------------------------------
`default_nettype none

module tgr_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_valid,
    output logic          o_s_ready,
    input  tgr_pkg::t_sts i_sts,
    output tgr_pkg::t_cmd o_cmd
);

    import tgr_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state   = r_state;
        o_cmd     = '0;
        o_s_ready = r_state == S_IDLE;
        unique case (r_state)
            S_IDLE: begin
                if (i_s_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = S_EVAL;
                end
            end
            S_EVAL: begin
                priority if (i_sts.glitch && !i_sts.rend && !i_sts.gap_full) begin
                    o_cmd.absorb = 1'b1;
                    n_state      = S_IDLE;
                end else if (!i_sts.in_glitch) begin
                    n_state = S_FINAL;
                end else if (i_sts.mode_interp) begin
                    o_cmd.start_div = 1'b1;
                    n_state         = S_DIV;
                end else begin
                    o_cmd.init_run = 1'b1;
                    n_state        = S_READ;
                end
            end
            S_DIV: begin
                if (i_sts.div_done) begin
                    o_cmd.init_run = 1'b1;
                    n_state        = S_READ;
                end
            end
            S_READ: begin
                o_cmd.rd_step = 1'b1;
                n_state       = S_EMIT;
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit_held = 1'b1;
                    n_state         = i_sts.idx_last ? S_FINAL : S_READ;
                end
            end
            S_FINAL: begin
                if (i_sts.out_free) begin
                    o_cmd.emit_final = 1'b1;
                    n_state          = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: src/threshold_glitch_remover.sv
// ---------------------------------------------------------------------------
// Threshold glitch remover
// Holds back runs of samples at or above a magnitude threshold and releases
// them as a straight line between the neighbouring good samples, as zeros,
// or unchanged.
// ---------------------------------------------------------------------------
//  Channel   Direction  Handshake               Payload
//  s_axis    in         tvalid / tready         tdata: sample; tlast: record_end
//  m_axis    out        tvalid / tready         tdata: sample_out; tuser: repaired,
//                                               run_last; tlast: record_end_out
//  cfg       in         write enable only       addr 0 threshold, 1 repair_mode
//
// A request that is held back is evaluated and returns to idle; one that closes no
// run also passes the final emit state. Closing a run of n held samples reads each
// held sample from the hold memory and then places it in the output register; linear
// interpolation first runs the serial divider.
// Reset is synchronous and active low; no clearing pass is needed.
// A stalled output delays emission; a new request is taken while the last
// result still waits in the output register.
// ---------------------------------------------------------------------------
`default_nettype none

module threshold_glitch_remover #(
    parameter int unsigned MAX_GAP      = 63,
    parameter int unsigned SAMPLE_WIDTH = 24
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_s_axis_tvalid,
    output logic                                    o_s_axis_tready,
    input  logic [((SAMPLE_WIDTH + 7) / 8) * 8-1:0] i_s_axis_tdata,  // sample
    input  logic                                    i_s_axis_tlast,
    output logic                                    o_m_axis_tvalid,
    input  logic                                    i_m_axis_tready,
    output logic [((SAMPLE_WIDTH + 7) / 8) * 8-1:0] o_m_axis_tdata,  // sample_out
    output logic [1:0]                              o_m_axis_tuser,  // repaired, run_last
    output logic                                    o_m_axis_tlast,
    input  logic                                    i_cfg_we,
    input  logic                                    i_cfg_addr,
    input  logic [tgr_pkg::CFG_WIDTH-1:0]           i_cfg_wdata
);

    import tgr_pkg::*;

    localparam int unsigned BW = ((SAMPLE_WIDTH + 7) / 8) * 8;

    t_cmd                    w_cmd;
    t_sts                    w_sts;
    logic [SAMPLE_WIDTH-1:0] w_sample_out;
    logic                    w_repaired;
    logic                    w_run_last;

    tgr_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (i_s_axis_tvalid),
        .o_s_ready (o_s_axis_tready),
        .i_sts     (w_sts),
        .o_cmd     (w_cmd)
    );

    tgr_dp #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .MAX_GAP      (MAX_GAP)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_sts            (w_sts),
        .i_sample         (i_s_axis_tdata[SAMPLE_WIDTH-1:0]),
        .i_record_end     (i_s_axis_tlast),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_addr       (i_cfg_addr),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_m_ready        (i_m_axis_tready),
        .o_m_valid        (o_m_axis_tvalid),
        .o_sample_out     (w_sample_out),
        .o_repaired       (w_repaired),
        .o_run_last       (w_run_last),
        .o_record_end_out (o_m_axis_tlast)
    );

    assign o_m_axis_tdata = BW'(w_sample_out);
    assign o_m_axis_tuser = {w_run_last, w_repaired};

endmodule

`default_nettype wire

FILE: test/threshold_glitch_remover_tb.sv
// ---------------------------------------------------------------------------
// Threshold glitch remover testbench
// Drives sample requests with random bursts and gaps, stalls the output at
// random, and checks every result against an in-bench model of the glitch
// run hold-back and its pass-through, interpolation and zero-fill repairs.
// ---------------------------------------------------------------------------
module threshold_glitch_remover_tb;

    import tgr_pkg::*;

    localparam int unsigned SAMPLE_W      = 24;
    localparam int unsigned MAX_GAP       = 63;
    localparam logic [1:0]  MODE_PASS     = 2'd0;
    localparam logic [1:0]  MODE_UNUSED   = 2'd3;
    localparam int          SETTLE_CYCLES = 300;
    localparam int          LONG_STALL    = 400;
    localparam int          TIMEOUT       = 2000000;

    typedef struct packed {
        logic [SAMPLE_W-1:0] smp;
        logic                rend;
    } t_request;

    typedef struct packed {
        logic [SAMPLE_W-1:0] smp;
        logic                repaired;
        logic                run_last;
        logic                rec_end;
    } t_result;

    typedef enum {RX_OPEN, RX_HALF, RX_SPARSE} t_rx_pattern;

    logic                  i_clk           = 1'b0;
    logic                  i_rst_n         = 1'b0;
    logic                  i_s_axis_tvalid = 1'b0;
    logic                  o_s_axis_tready;
    logic [SAMPLE_W-1:0]   i_s_axis_tdata  = '0;  // sample
    logic                  i_s_axis_tlast  = 1'b0;
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready = 1'b0;
    logic [SAMPLE_W-1:0]   o_m_axis_tdata;        // sample_out
    logic [1:0]            o_m_axis_tuser;        // repaired, run_last
    logic                  o_m_axis_tlast;
    logic                  i_cfg_we        = 1'b0;
    logic                  i_cfg_addr      = 1'b0;
    logic [CFG_WIDTH-1:0]  i_cfg_wdata     = '0;

    t_request pending_requests[$];
    t_result  expected_results[$];
    int       err_cnt = 0;
    bit       s_taken = 1'b0;

    logic [CFG_WIDTH-1:0] cfg_threshold = THRESHOLD_RESET;
    logic [1:0]           cfg_mode      = MODE_PASS;

    bit     run_open = 1'b0;
    longint left_val = 0;
    int     gap_cnt  = 0;
    longint held_smp[MAX_GAP];

    int          burst_left = 0;
    int          gap_left   = 0;
    int          stall_req  = 0;
    int          stall_done = 0;
    int          hold_left  = 0;
    int          rx_left    = 0;
    t_rx_pattern rx_kind    = RX_OPEN;

    threshold_glitch_remover #(
        .MAX_GAP      (MAX_GAP),
        .SAMPLE_WIDTH (SAMPLE_W)
    ) u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_wdata     (i_cfg_wdata)
    );

    always #2 i_clk = ~i_clk;

    function automatic void add_expected(longint v, bit rep, bit last, bit rend);
        t_result r;
        r.smp      = v[SAMPLE_W-1:0];
        r.repaired = rep;
        r.run_last = last;
        r.rec_end  = rend;
        expected_results.push_back(r);
    endfunction

    // Works out the results of one accepted request and advances the run state.
    task automatic deglitch_predict(input t_request req);
        logic signed [SAMPLE_W-1:0] ss;
        longint s;
        longint m;
        longint mag;
        bit     glitch;
        int     i;
        ss     = req.smp;
        s      = ss;
        mag    = (s < 0) ? -s : s;
        glitch = mag >= longint'(cfg_threshold);
        if (!run_open) begin
            if (glitch && !req.rend) begin
                run_open    = 1'b1;
                held_smp[0] = s;
                gap_cnt     = 1;
                return;
            end
            add_expected(s, 1'b0, 1'b1, req.rend);
        end else if (glitch && !req.rend && gap_cnt < MAX_GAP) begin
            held_smp[gap_cnt] = s;
            gap_cnt++;
            return;
        end else begin
            m = gap_cnt + 1;
            for (i = 0; i < gap_cnt; i++) begin
                if (cfg_mode == MODE_INTERP)
                    add_expected((left_val * m + (s - left_val) * (i + 1)) / m, 1'b1, 1'b0, 1'b0);
                else if (cfg_mode == MODE_ZERO)
                    add_expected(0, 1'b1, 1'b0, 1'b0);
                else
                    add_expected(held_smp[i], 1'b0, 1'b0, 1'b0);
            end
            add_expected(s, 1'b0, 1'b1, req.rend);
            run_open = 1'b0;
            gap_cnt  = 0;
        end
        if (req.rend) begin
            left_val = 0;
            run_open = 1'b0;
            gap_cnt  = 0;
        end else begin
            left_val = s;
        end
    endtask

    function automatic void flag_mismatch(t_result want, t_result got, bit unexpected);
        err_cnt++;
        if (err_cnt <= 10) begin
            if (unexpected)
                $display("Unexpected result: sample %h repaired %b run_last %b record_end %b",
                         got.smp, got.repaired, got.run_last, got.rec_end);
            else
                $display("Mismatch: expected %h %b %b %b, got %h %b %b %b",
                         want.smp, want.repaired, want.run_last, want.rec_end,
                         got.smp, got.repaired, got.run_last, got.rec_end);
        end
    endfunction

    always @(posedge i_clk) begin
        t_request req;
        t_result  got;
        t_result  want;
        if (!i_rst_n) begin
            s_taken = 1'b0;
        end else begin
            s_taken = i_s_axis_tvalid && o_s_axis_tready;
            if (s_taken) begin
                req.smp  = i_s_axis_tdata;
                req.rend = i_s_axis_tlast;
                deglitch_predict(req);
            end
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                got.smp      = o_m_axis_tdata;
                got.repaired = o_m_axis_tuser[0];
                got.run_last = o_m_axis_tuser[1];
                got.rec_end  = o_m_axis_tlast;
                if (expected_results.size() == 0) begin
                    flag_mismatch(got, got, 1'b1);
                end else begin
                    want = expected_results.pop_front();
                    if (got !== want)
                        flag_mismatch(want, got, 1'b0);
                end
            end
        end
    end

    // Sender: bursts of random length separated by random gaps.
    always @(negedge i_clk) begin
        t_request req;
        if (!i_s_axis_tvalid || s_taken) begin
            if (gap_left != 0 || pending_requests.size() == 0) begin
                if (gap_left != 0)
                    gap_left--;
                i_s_axis_tvalid <= 1'b0;
            end else begin
                req = pending_requests.pop_front();
                i_s_axis_tdata  <= req.smp;
                i_s_axis_tlast  <= req.rend;
                i_s_axis_tvalid <= 1'b1;
                if (burst_left > 0)
                    burst_left--;
                if (burst_left == 0) begin
                    burst_left = $urandom_range(24, 1);
                    gap_left   = ($urandom_range(2, 0) == 0) ? 0 : $urandom_range(6, 1);
                end
            end
        end
    end

    // Receiver: changing stall patterns, plus a long hold-off on demand.
    always @(negedge i_clk) begin
        if (stall_req != stall_done) begin
            stall_done++;
            hold_left = LONG_STALL;
        end
        if (hold_left != 0) begin
            hold_left--;
            i_m_axis_tready <= 1'b0;
        end else begin
            if (rx_left == 0) begin
                rx_kind = t_rx_pattern'($urandom_range(2, 0));
                rx_left = $urandom_range(64, 8);
            end else begin
                rx_left--;
            end
            case (rx_kind)
                RX_OPEN: begin
                    i_m_axis_tready <= 1'b1;
                end
                RX_HALF: begin
                    i_m_axis_tready <= 1'($urandom_range(1, 0));
                end
                default: begin
                    i_m_axis_tready <= ($urandom_range(3, 0) == 0);
                end
            endcase
        end
    end

    function automatic void queue_req(int value, bit rend);
        t_request req;
        req.smp  = value[SAMPLE_W-1:0];
        req.rend = rend;
        pending_requests.push_back(req);
    endfunction

    function automatic int good_sample();
        int unsigned mag;
        if (cfg_threshold == 0)
            return int'($urandom());
        mag = $urandom_range(int'(cfg_threshold) - 1, 0);
        return $urandom_range(1, 0) ? -int'(mag) : int'(mag);
    endfunction

    function automatic int glitch_sample();
        int unsigned mag;
        mag = $urandom_range(32'h800000, int'(cfg_threshold));
        if (mag == 32'h800000)
            return -int'(mag);
        return $urandom_range(1, 0) ? -int'(mag) : int'(mag);
    endfunction

    function automatic void queue_random(int value);
        if ($urandom_range(9, 0) == 0)
            queue_req(int'($urandom()), $urandom_range(11, 0) == 0);
        else
            queue_req(value, $urandom_range(11, 0) == 0);
    endfunction

    task automatic write_reg(input logic addr, input logic [CFG_WIDTH-1:0] data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= addr;
        i_cfg_wdata <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (addr == REG_THRESHOLD)
            cfg_threshold = data;
        else
            cfg_mode = data[1:0];
    endtask

    task automatic drain();
        while (pending_requests.size() != 0 || i_s_axis_tvalid || expected_results.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic random_phase(input int n_req, input bit long_run);
        int  cnt;
        int  k;
        int  glen;
        bit  long_left;
        cnt       = 0;
        long_left = long_run;
        while (cnt < n_req) begin
            glen = $urandom_range(4, 0);
            for (k = 0; k < glen; k++) begin
                queue_random(good_sample());
                cnt++;
            end
            if (long_left) begin
                // The long run stays unbroken so that it reaches the held sample limit.
                for (k = 0; k < 66; k++) begin
                    queue_req(glitch_sample(), 1'b0);
                    cnt++;
                end
                glen      = 0;
                long_left = 1'b0;
            end else if ($urandom_range(11, 0) == 0) begin
                glen = $urandom_range(20, 7);
            end else begin
                glen = $urandom_range(6, 1);
            end
            for (k = 0; k < glen; k++) begin
                queue_random(glitch_sample());
                cnt++;
            end
            queue_random(good_sample());
            cnt++;
        end
    endtask

    initial begin
        int p;
        int thr;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: the most negative sample is a glitch, held samples pass unchanged.
        queue_req(0, 1'b0);
        queue_req(8388607, 1'b0);
        queue_req(-8388608, 1'b0);
        queue_req(5, 1'b0);
        queue_req(-1, 1'b1);
        drain();

        write_reg(REG_THRESHOLD, 24'd1000);
        write_reg(REG_REPAIR_MODE, CFG_WIDTH'(MODE_INTERP));
        queue_req(3000, 1'b0);
        queue_req(-5000, 1'b0);
        queue_req(100, 1'b0);
        queue_req(200, 1'b0);
        queue_req(2000, 1'b1);
        queue_req(-300, 1'b0);
        queue_req(8388607, 1'b0);
        queue_req(-8388608, 1'b0);
        queue_req(-999, 1'b0);
        queue_req(1500, 1'b0);
        queue_req(-1500, 1'b0);
        queue_req(2500, 1'b1);
        queue_req(1200, 1'b0);
        drain();

        // The mode is changed while a run is still held.
        write_reg(REG_REPAIR_MODE, CFG_WIDTH'(MODE_ZERO));
        queue_req(-1600, 1'b0);
        queue_req(999, 1'b1);
        drain();

        write_reg(REG_THRESHOLD, 24'd0);
        write_reg(REG_REPAIR_MODE, CFG_WIDTH'(MODE_UNUSED));
        queue_req(7, 1'b0);
        queue_req(-7, 1'b0);
        queue_req(0, 1'b1);
        drain();

        for (p = 0; p < 5; p++) begin
            case ($urandom_range(4, 0))
                0:       thr = $urandom_range(64, 1);
                1:       thr = (p == 2) ? 0 : int'(THRESHOLD_RESET);
                default: thr = $urandom_range(32'h800000, 1);
            endcase
            if (p == 0)
                thr = $urandom_range(4000, 100);
            write_reg(REG_THRESHOLD, thr[CFG_WIDTH-1:0]);
            write_reg(REG_REPAIR_MODE,
                      CFG_WIDTH'((p == 0) ? MODE_INTERP : 2'($urandom_range(3, 0))));
            if (p == 1)
                stall_req++;
            random_phase((p == 0) ? 67 : 4, p == 0);
            drain();
        end

        if (err_cnt == 0) begin
            $display("** threshold_glitch_remover: PASSED **");
        end else begin
            $display("** threshold_glitch_remover: FAILED **");
        end
        $finish;
    end

    initial begin
        #(TIMEOUT);
        $display("** threshold_glitch_remover: FAILED **");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+src
src/tgr_pkg.sv
src/tgr_div.sv
src/tgr_dp.sv
src/tgr_ctrl.sv
src/threshold_glitch_remover.sv
test/threshold_glitch_remover_tb.sv
